[rtl/two_wire_humidity_sensor_master_top_defines.svh]
// Assertion macros for the RTL of the two-wire sensor master.
// Every macro expects clk and rst_n in the scope where it is used.
`ifndef TWO_WIRE_HUMIDITY_SENSOR_MASTER_TOP_DEFINES_SVH
`define TWO_WIRE_HUMIDITY_SENSOR_MASTER_TOP_DEFINES_SVH

// Consequence checked in the same cycle as the antecedent.
`define TWHSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define TWHSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/twhsm_pkg.sv]
`default_nettype none

package twhsm_pkg;

  typedef enum logic [20:0] {
    PH_IDLE      = 21'h000001,
    PH_START     = 21'h000002,
    PH_CPRE      = 21'h000004,
    PH_CSETUP    = 21'h000008,
    PH_CHIGH     = 21'h000010,
    PH_CACKWAIT  = 21'h000020,
    PH_CACKLOW   = 21'h000040,
    PH_CACKHIGH  = 21'h000080,
    PH_GAP       = 21'h000100,
    PH_READYWAIT = 21'h000200,
    PH_RHIGH     = 21'h000400,
    PH_RLOW      = 21'h000800,
    PH_ALOW      = 21'h001000,
    PH_AHIGH     = 21'h002000,
    PH_AEND      = 21'h004000,
    PH_SKIPLOW   = 21'h008000,
    PH_SKIPHIGH  = 21'h010000,
    PH_FSKIPLOW  = 21'h020000,
    PH_FSKIPHIGH = 21'h040000,
    PH_FSTART    = 21'h080000,
    PH_PAUSE     = 21'h100000
  } phase_t;

  localparam int unsigned HALF_W  = 8;
  localparam int unsigned LIMIT_W = 19;
  localparam int unsigned GAP_W   = 8;
  localparam int unsigned PAUSE_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAIT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CMD_GAP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_END_PAUSE   = 2'd3;

  localparam logic [HALF_W-1:0]  HALF_PERIOD_RST = 8'd4;
  localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST  = 19'd400000;
  localparam logic [GAP_W-1:0]   CMD_GAP_RST     = 8'd80;
  localparam logic [PAUSE_W-1:0] END_PAUSE_RST   = 17'd100000;

  localparam logic [7:0] CMD_TEMPERATURE = 8'h03;
  localparam logic [7:0] CMD_HUMIDITY    = 8'h05;

  typedef struct packed {
    logic [HALF_W-1:0]  half_period_ticks;
    logic [LIMIT_W-1:0] wait_limit_ticks;
    logic [GAP_W-1:0]   command_gap_ticks;
    logic [PAUSE_W-1:0] end_pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic        clock_out;
    logic        data_drive_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
    logic        wait_failed;
  } res_t;

endpackage

`default_nettype wire

[rtl/two_wire_humidity_sensor_master_top.sv]
// Two-wire sensor master clocked by time-base ticks: every input word is one tick and
// yields one result word holding the line levels, status and the last raw readings.
// A word passes through an input register, one step of the sequencer and a result
// register; one word is taken in every cycle while out_stall is low, as the sequencer
// steps within the cycle.  The user must write configuration only while no word is
// in flight; the block itself does not enforce this.
`default_nettype none

`include "two_wire_humidity_sensor_master_top_defines.svh"

module two_wire_humidity_sensor_master_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_start_req,
  input  logic                              in_data_in,
  input  logic                              in_abort_n,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_clock_out,
  output logic                              out_data_drive_low,
  output logic                              out_busy_res,
  output logic                              out_done_res,
  output logic [15:0]                       out_temperature_raw,
  output logic [15:0]                       out_humidity_raw,
  output logic                              out_wait_failed,
  input  logic                              cfg_we,
  input  logic [twhsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twhsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import twhsm_pkg::*;

  logic in_valid_r;
  logic in_start_req_r;
  logic in_data_in_r;
  logic in_abort_n_r;
  logic out_valid_r;
  res_t out_res_r;

  cfg_t cfg;
  res_t step_res;
  logic out_ready;
  logic advance;
  logic in_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign in_stall  = !in_ready;

  twhsm_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  twhsm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .start_req (in_start_req_r),
    .data_in   (in_data_in_r),
    .abort_n   (in_abort_n_r),
    .cfg       (cfg),
    .res       (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_ready) begin
        out_valid_r <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_start_req_r <= in_start_req;
      in_data_in_r   <= in_data_in;
      in_abort_n_r   <= in_abort_n;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_clock_out       = out_res_r.clock_out;
  assign out_data_drive_low  = out_res_r.data_drive_low;
  assign out_busy_res        = out_res_r.busy_res;
  assign out_done_res        = out_res_r.done_res;
  assign out_temperature_raw = out_res_r.temperature_raw;
  assign out_humidity_raw    = out_res_r.humidity_raw;
  assign out_wait_failed     = out_res_r.wait_failed;

  `TWHSM_ASSERT_SAME(a_done_while_busy, out_valid_r && out_res_r.done_res, out_res_r.busy_res, "done word shown outside a measurement cycle")
  `TWHSM_ASSERT_SAME(a_idle_lines_released, out_valid_r && !out_res_r.busy_res, !out_res_r.clock_out && !out_res_r.data_drive_low, "lines driven while idle")
  `TWHSM_ASSERT_NEXT(a_held_word_kept, in_valid_r && out_valid_r && out_stall, in_valid_r, "word in the input register lost while the result side stalls")

endmodule

`default_nettype wire

[rtl/twhsm_cfg_regs.sv]
`default_nettype none

module twhsm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [twhsm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [twhsm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output twhsm_pkg::cfg_t                     cfg
);
  import twhsm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_PERIOD_RST;
      cfg_r.wait_limit_ticks  <= WAIT_LIMIT_RST;
      cfg_r.command_gap_ticks <= CMD_GAP_RST;
      cfg_r.end_pause_ticks   <= END_PAUSE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_wdata[HALF_W-1:0];
        CFG_IDX_WAIT_LIMIT:  cfg_r.wait_limit_ticks  <= cfg_wdata[LIMIT_W-1:0];
        CFG_IDX_CMD_GAP:     cfg_r.command_gap_ticks <= cfg_wdata[GAP_W-1:0];
        CFG_IDX_END_PAUSE:   cfg_r.end_pause_ticks   <= cfg_wdata[PAUSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/twhsm_core.sv]
`default_nettype none

module twhsm_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  logic            start_req,
  input  logic            data_in,
  input  logic            abort_n,
  input  twhsm_pkg::cfg_t cfg,
  output twhsm_pkg::res_t res
);
  import twhsm_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [16:0] tick_count_r, tick_count_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [15:0] shift_word_r, shift_word_nxt;
  logic [18:0] wait_count_r, wait_count_nxt;
  logic        measuring_r, measuring_nxt;
  logic [15:0] temperature_r, temperature_nxt;
  logic [15:0] humidity_r, humidity_nxt;
  logic        failed_r, failed_nxt;
  logic        done_nxt;

  logic [16:0] seg_len;
  logic [16:0] seg_len_eff;
  logic [16:0] tick_inc;
  logic        seg_done;
  logic [16:0] tick_seg;
  logic        wait_fail;
  logic        wait_done;
  logic [18:0] wait_inc;
  logic [7:0]  cmd;
  logic        cmd_low;

  always_comb begin
    case (phase_r)
      PH_START, PH_FSTART: seg_len = {10'd0, cfg.half_period_ticks[7:1]};
      PH_GAP:              seg_len = {9'd0, cfg.command_gap_ticks};
      PH_PAUSE:            seg_len = cfg.end_pause_ticks;
      default:             seg_len = {9'd0, cfg.half_period_ticks};
    endcase
  end

  assign seg_len_eff = (seg_len == 17'd0) ? 17'd1 : seg_len;
  assign tick_inc    = tick_count_r + 17'd1;
  assign seg_done    = (tick_inc >= seg_len_eff);
  assign tick_seg    = seg_done ? 17'd0 : tick_inc;

  assign wait_fail = data_in && ((wait_count_r >= cfg.wait_limit_ticks) || !abort_n);
  assign wait_done = !data_in || wait_fail;
  assign wait_inc  = wait_count_r + 19'd1;

  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    bit_count_nxt   = bit_count_r;
    shift_word_nxt  = shift_word_r;
    wait_count_nxt  = wait_count_r;
    measuring_nxt   = measuring_r;
    temperature_nxt = temperature_r;
    humidity_nxt    = humidity_r;
    failed_nxt      = failed_r;
    done_nxt        = 1'b0;

    case (phase_r)
      PH_IDLE: begin
        if (start_req) begin
          failed_nxt     = 1'b0;
          measuring_nxt  = 1'b0;
          bit_count_nxt  = 4'd0;
          phase_nxt      = PH_START;
          tick_count_nxt = 17'd0;
          wait_count_nxt = 19'd0;
        end
      end
      PH_START, PH_FSTART: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          if (bit_count_r < 4'd5) begin
            bit_count_nxt = bit_count_r + 4'd1;
          end else begin
            bit_count_nxt  = 4'd0;
            phase_nxt      = (phase_r == PH_START) ? PH_CPRE : PH_PAUSE;
            wait_count_nxt = 19'd0;
          end
        end
      end
      PH_CPRE: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          bit_count_nxt  = 4'd0;
          phase_nxt      = PH_CSETUP;
          wait_count_nxt = 19'd0;
        end
      end
      PH_CSETUP: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          phase_nxt      = PH_CHIGH;
          wait_count_nxt = 19'd0;
        end
      end
      PH_CHIGH: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          wait_count_nxt = 19'd0;
          if (bit_count_r < 4'd7) begin
            bit_count_nxt = bit_count_r + 4'd1;
            phase_nxt     = PH_CSETUP;
          end else begin
            phase_nxt = PH_CACKWAIT;
          end
        end
      end
      PH_CACKWAIT, PH_READYWAIT: begin
        if (wait_done) begin
          if (wait_fail) begin
            failed_nxt = 1'b1;
          end
          tick_count_nxt = 17'd0;
          wait_count_nxt = 19'd0;
          if (phase_r == PH_CACKWAIT) begin
            phase_nxt = PH_CACKLOW;
          end else begin
            bit_count_nxt  = 4'd0;
            shift_word_nxt = 16'd0;
            phase_nxt      = PH_RHIGH;
          end
        end else begin
          wait_count_nxt = wait_inc;
        end
      end
      PH_CACKLOW: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          phase_nxt      = PH_CACKHIGH;
          wait_count_nxt = 19'd0;
        end
      end
      PH_CACKHIGH: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          phase_nxt      = PH_GAP;
          wait_count_nxt = 19'd0;
        end
      end
      PH_GAP: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          phase_nxt      = PH_READYWAIT;
          wait_count_nxt = 19'd0;
        end
      end
      PH_RHIGH: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          shift_word_nxt = {shift_word_r[14:0], data_in};
          phase_nxt      = PH_RLOW;
          wait_count_nxt = 19'd0;
        end
      end
      PH_RLOW: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          wait_count_nxt = 19'd0;
          if (bit_count_r == 4'd7) begin
            bit_count_nxt = 4'd8;
            phase_nxt     = PH_ALOW;
          end else if (bit_count_r >= 4'd15) begin
            bit_count_nxt = 4'd0;
            if (!measuring_r) begin
              temperature_nxt = shift_word_r;
              measuring_nxt   = 1'b1;
              phase_nxt       = PH_SKIPLOW;
            end else begin
              humidity_nxt = shift_word_r;
              done_nxt     = 1'b1;
              phase_nxt    = PH_FSKIPLOW;
            end
          end else begin
            bit_count_nxt = bit_count_r + 4'd1;
            phase_nxt     = PH_RHIGH;
          end
        end
      end
      PH_ALOW: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          phase_nxt      = PH_AHIGH;
          wait_count_nxt = 19'd0;
        end
      end
      PH_AHIGH: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          phase_nxt      = PH_AEND;
          wait_count_nxt = 19'd0;
        end
      end
      PH_AEND: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          phase_nxt      = PH_RHIGH;
          wait_count_nxt = 19'd0;
        end
      end
      PH_SKIPLOW, PH_FSKIPLOW: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          phase_nxt      = (phase_r == PH_SKIPLOW) ? PH_SKIPHIGH : PH_FSKIPHIGH;
          wait_count_nxt = 19'd0;
        end
      end
      PH_SKIPHIGH, PH_FSKIPHIGH: begin
        tick_count_nxt = tick_seg;
        if (seg_done) begin
          wait_count_nxt = 19'd0;
          if (bit_count_r < 4'd8) begin
            bit_count_nxt = bit_count_r + 4'd1;
            phase_nxt     = (phase_r == PH_SKIPHIGH) ? PH_SKIPLOW : PH_FSKIPLOW;
          end else begin
            bit_count_nxt = 4'd0;
            phase_nxt     = (phase_r == PH_SKIPHIGH) ? PH_START : PH_FSTART;
          end
        end
      end
      PH_PAUSE: begin
        if (!abort_n) begin
          phase_nxt      = PH_IDLE;
          tick_count_nxt = 17'd0;
          wait_count_nxt = 19'd0;
        end else begin
          tick_count_nxt = tick_seg;
          if (seg_done) begin
            phase_nxt      = PH_IDLE;
            wait_count_nxt = 19'd0;
          end
        end
      end
      default: begin
        phase_nxt      = PH_IDLE;
        tick_count_nxt = 17'd0;
        wait_count_nxt = 19'd0;
      end
    endcase
  end

  // Line levels follow the state that this tick leaves behind.
  assign cmd     = measuring_nxt ? CMD_HUMIDITY : CMD_TEMPERATURE;
  assign cmd_low = ~cmd[~bit_count_nxt[2:0]];

  always_comb begin
    res.clock_out       = 1'b0;
    res.data_drive_low  = 1'b0;
    res.busy_res        = (phase_nxt != PH_IDLE);
    res.done_res        = done_nxt;
    res.temperature_raw = temperature_nxt;
    res.humidity_raw    = humidity_nxt;
    res.wait_failed     = failed_nxt;
    case (phase_nxt)
      PH_START, PH_FSTART: begin
        res.clock_out = (bit_count_nxt == 4'd1) || (bit_count_nxt == 4'd2) ||
                        (bit_count_nxt >= 4'd4);
        res.data_drive_low = (bit_count_nxt >= 4'd2) && (bit_count_nxt <= 4'd4);
      end
      PH_CSETUP: begin
        res.data_drive_low = cmd_low;
      end
      PH_CHIGH: begin
        res.clock_out      = 1'b1;
        res.data_drive_low = cmd_low;
      end
      PH_CACKHIGH, PH_RHIGH, PH_SKIPHIGH, PH_FSKIPHIGH: begin
        res.clock_out = 1'b1;
      end
      PH_ALOW, PH_AEND: begin
        res.data_drive_low = 1'b1;
      end
      PH_AHIGH: begin
        res.clock_out      = 1'b1;
        res.data_drive_low = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= 17'd0;
      bit_count_r   <= 4'd0;
      shift_word_r  <= 16'd0;
      wait_count_r  <= 19'd0;
      measuring_r   <= 1'b0;
      temperature_r <= 16'd0;
      humidity_r    <= 16'd0;
      failed_r      <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      bit_count_r   <= bit_count_nxt;
      shift_word_r  <= shift_word_nxt;
      wait_count_r  <= wait_count_nxt;
      measuring_r   <= measuring_nxt;
      temperature_r <= temperature_nxt;
      humidity_r    <= humidity_nxt;
      failed_r      <= failed_nxt;
    end
  end

endmodule

`default_nettype wire
